// ----- hdl/psvb_pkg.sv -----
// Shared types, constants and table functions of the sine voice bank.
`default_nettype none
package psvb_pkg;

  localparam int MODE_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int QTR_W      = 15;   // quarter-wave magnitude, 0..32767
  localparam int SINE_W     = 16;
  localparam int SV_W       = 24;   // sine * velocity
  localparam int PROD_W     = 41;   // sine * velocity * gain
  localparam int SAMPLE_W   = 23;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd7864;

  // Output rounding: |acc| / (127 * 2^16), half away from zero.
  localparam logic [22:0] MIX_RND = 23'd4161536;
  // At or above this quotient numerator (after the >>16) the result saturates.
  localparam logic [29:0] SAT_T   = 30'd532676608;
  // floor(2^37 / 127)
  localparam logic [30:0] RECIP   = 31'd1082196484;
  localparam int RECIP_SH = 37;

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 23'sd4194303;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -23'sd4194304;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Notes 120..131 in Q16 Hz.
  localparam logic [31:0] TOP_OCT_Q16 [12] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_NOTE_ON  = 2'd0,
    MODE_NOTE_OFF = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Quarter-wave entry: round(32767 * sin(pi/2 * idx / 2^tbits)), Taylor series in Q30.
  function automatic logic [QTR_W-1:0] quarter_value(input int unsigned idx,
                                                     input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(HALF_PI_Q30) * 64'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[QTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/psvb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module psvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/psvb_mac.sv -----
// Per-voice sine lookup, velocity and gain scaling, and sample accumulator.
`default_nettype none
module psvb_mac
  import psvb_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int ACC_W           = 49
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_ctl_t                ctl_i,
  input  wire logic [PHASE_BITS-1:0]   phase_i,
  input  wire logic [VEL_W-1:0]        vel_i,
  input  wire logic [GAIN_W-1:0]       gain_i,
  output logic signed [ACC_W-1:0]      acc_o,
  output logic                         acc_vld_o
);
  localparam int QTR = 1 << SINE_TABLE_BITS;
  localparam int TA_W = SINE_TABLE_BITS + 1;

  logic [QTR_W-1:0] qtr_tbl [QTR+1];

  for (genvar gi = 0; gi <= QTR; gi++) begin : g_qtr
    localparam logic [QTR_W-1:0] QV = quarter_value(gi, SINE_TABLE_BITS);
    assign qtr_tbl[gi] = QV;
  end

  logic [SINE_TABLE_BITS+1:0]   pos;
  logic [SINE_TABLE_BITS-1:0]   tidx;
  logic [TA_W-1:0]              taddr;
  logic [QTR_W-1:0]             tval;
  logic signed [SINE_W-1:0]     sine_d;

  mac_ctl_t                     ctl1_q, ctl2_q, ctl3_q;
  logic [QTR_W-1:0]             tval_q;
  logic                         sneg_q;
  logic [VEL_W-1:0]             vel1_q;
  logic signed [SV_W-1:0]       sv_d, sv_q;
  logic signed [PROD_W-1:0]     prod_d, prod_q;
  logic signed [ACC_W-1:0]      acc_d, acc_q;
  logic                         acc_vld_q;

  always_comb begin
    pos   = phase_i[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    tidx  = pos[SINE_TABLE_BITS-1:0];
    // odd quadrants run the table backwards
    taddr = pos[SINE_TABLE_BITS] ? (TA_W'(QTR) - TA_W'(tidx)) : TA_W'(tidx);
    tval  = qtr_tbl[taddr];
    sine_d = sneg_q ? -$signed({1'b0, tval_q}) : $signed({1'b0, tval_q});
    sv_d   = sine_d * $signed({1'b0, vel1_q});
    prod_d = sv_q * $signed({1'b0, gain_i});
    acc_d  = ctl3_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q    <= '0;
      ctl2_q    <= '0;
      ctl3_q    <= '0;
      acc_vld_q <= 1'b0;
    end else begin
      ctl1_q    <= ctl_i;
      ctl2_q    <= ctl1_q;
      ctl3_q    <= ctl2_q;
      acc_vld_q <= ctl3_q.vld && ctl3_q.last;
    end
  end

  // table read is registered so the quarter-wave table maps onto a ROM
  always_ff @(posedge clk_i) begin
    tval_q <= tval;
    sneg_q <= pos[SINE_TABLE_BITS+1];
    vel1_q <= vel_i;
    sv_q   <= sv_d;
    prod_q <= prod_d;
    if (ctl3_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o     = acc_q;
  assign acc_vld_o = acc_vld_q;

  // the running sum is only handed out after a first voice opened it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl3_q.vld && ctl3_q.last |-> $past(ctl2_q.vld, 1) || ctl3_q.first)
    else $error("mac: last voice without a preceding voice");

endmodule
`default_nettype wire

// ----- hdl/psvb_scale.sv -----
// Rounds the accumulated mix by 127 * 2^16 and saturates it to the output format.
`default_nettype none
module psvb_scale
  import psvb_pkg::*;
#(
  parameter int ACC_W = 49
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [ACC_W-1:0] acc_i,
  output logic signed [SAMPLE_W-1:0]   sample_o,
  output logic                         done_o
);
  localparam int MW = ACC_W + 1;
  localparam int TW = (ACC_W - 16 > 30) ? (ACC_W - 16) : 30;
  localparam int PW = 61;
  localparam int QW = PW - RECIP_SH;

  logic [3:0]                  vld_q;
  logic                        done_q;

  logic [ACC_W-1:0]            mag_d, mag_q;
  logic                        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [MW-1:0]               m_w;
  logic [TW-1:0]               t_w;
  logic [29:0]                 t2_q, t3_q;
  logic                        sat2_q, sat3_q, sat4_q;
  logic [PW-1:0]               prod_d, prod_q;
  logic [QW-1:0]               qest_w, q4_q, qfix_w;
  logic [30:0]                 r_d, r4_q;
  logic signed [SAMPLE_W-1:0]  sample_d, sample_q;

  always_comb begin
    mag_d  = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    m_w    = MW'(mag_q) + MW'(MIX_RND);
    t_w    = TW'(m_w >> 16);
    prod_d = PW'(t2_q) * PW'(RECIP);
    qest_w = prod_q[PW-1:RECIP_SH];
    // estimate is exact or one low
    r_d    = 31'(t3_q) - 31'({qest_w, 7'd0} - {7'd0, qest_w});
    qfix_w = (r4_q >= 31'd127) ? q4_q + QW'(1) : q4_q;
    if (sat4_q) begin
      sample_d = neg4_q ? OUT_MIN : OUT_MAX;
    end else if (neg4_q) begin
      sample_d = -$signed(SAMPLE_W'(qfix_w));
    end else begin
      sample_d = $signed(SAMPLE_W'(qfix_w));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], start_i};
      done_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg1_q <= acc_i[ACC_W-1];
    t2_q   <= t_w[29:0];
    sat2_q <= (t_w >= TW'(SAT_T));
    neg2_q <= neg1_q;
    prod_q <= prod_d;
    t3_q   <= t2_q;
    sat3_q <= sat2_q;
    neg3_q <= neg2_q;
    q4_q   <= qest_w;
    r4_q   <= r_d;
    sat4_q <= sat3_q;
    neg4_q <= neg3_q;
    if (vld_q[3]) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;
  assign done_o   = done_q;

endmodule
`default_nettype wire

// ----- hdl/polyphonic_sine_voice_bank_unit.sv -----
// Top level: note event handling, voice walk over the state RAM, and output register.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser mode, tdata note/velocity
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata sample/any_active
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_data_i master_gain
//
// Note on: read, then write back. Note off and clear finish in the idle state.
// Sample tick: one voice per cycle through the RAM port, then the MAC and scale
// pipelines and the output load.
// Reset clears every voice at once through per-voice valid and active flops.
// A result waits in the output register; a tick stalls at its end only if that
// register is still full.
`default_nettype none
module polyphonic_sine_voice_bank_unit
  import psvb_pkg::*;
#(
  parameter int NUM_VOICES      = 128,
  parameter int SAMPLE_RATE_HZ  = 48000,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [6:0] note_number, [13:7] velocity
  input  wire logic [MODE_W-1:0]       s_axis_tuser,   // [1:0] mode
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // [22:0] mixed_sample, [23] any_active
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [GAIN_W-1:0]       cfg_data_i
);
  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int WW    = PHASE_BITS + VEL_W;
  localparam int ACC_W = PROD_W + $clog2(NUM_VOICES) + 1;
  localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOTE_RD,
    S_NOTE_WR,
    S_TICK_RUN,
    S_TICK_WAIT,
    S_TICK_HOLD
  } state_e;

  // per-note phase increment
  logic [PHASE_BITS-1:0] step_tbl [NUM_VOICES];

  for (genvar gv = 0; gv < NUM_VOICES; gv++) begin : g_step
    localparam int unsigned OCT = gv / 12;
    localparam int unsigned SH  = (10 - OCT) + (32 - PHASE_BITS);
    localparam logic [63:0] NUMR = {16'd0, TOP_OCT_Q16[gv % 12], 16'd0};
    localparam logic [63:0] DEN  = 64'(SAMPLE_RATE_HZ) << SH;
    localparam logic [63:0] STEP = (NUMR + DEN / 64'd2) / DEN;
    assign step_tbl[gv] = STEP[PHASE_BITS-1:0];
  end

  state_e                      state_q;
  logic [GAIN_W-1:0]           gain_q;
  logic [NUM_VOICES-1:0]       active_q;
  logic [NUM_VOICES-1:0]       valid_q;
  logic [VW-1:0]               cnt_q;
  logic                        s1_vld_q, s1_first_q, s1_last_q;
  logic [VW-1:0]               s1_idx_q;
  logic [VW-1:0]               note_idx_q;
  logic [VEL_W-1:0]            vel_q;
  mac_ctl_t                    mac_ctl_q;
  logic [PHASE_BITS-1:0]       mac_phase_q;
  logic [VEL_W-1:0]            mac_vel_q;
  logic                        m_valid_q;
  logic [OUT_TDATA_W-1:0]      out_data_q;

  mode_e                       in_mode;
  logic [NOTE_W-1:0]           in_note;
  logic [VEL_W-1:0]            in_vel;
  logic                        note_ok;
  logic [VW-1:0]               in_idx;

  logic                        ram_we, ram_re;
  logic [VW-1:0]               ram_waddr, ram_raddr;
  logic [WW-1:0]               ram_wdata, ram_rdata;
  logic [PHASE_BITS-1:0]       rd_phase, phase_eff;
  logic [VEL_W-1:0]            rd_vel;
  logic [VW-1:0]               cur_idx;
  logic                        voice_on;
  logic                        load_out;

  logic signed [ACC_W-1:0]     mac_acc;
  logic                        mac_acc_vld;
  logic signed [SAMPLE_W-1:0]  scale_sample;
  logic                        scale_done;

  always_comb begin
    in_mode  = mode_e'(s_axis_tuser);
    in_note  = s_axis_tdata[NOTE_W-1:0];
    in_vel   = s_axis_tdata[NOTE_W +: VEL_W];
    note_ok  = (8'(in_note) < 8'(NUM_VOICES));
    in_idx   = in_note[VW-1:0];

    rd_vel   = ram_rdata[VEL_W-1:0];
    rd_phase = ram_rdata[WW-1:VEL_W];
    cur_idx  = (state_q == S_NOTE_WR) ? note_idx_q : s1_idx_q;
    // never-written entries read as phase zero
    phase_eff = valid_q[cur_idx] ? rd_phase : '0;
    voice_on  = s1_vld_q && active_q[s1_idx_q];
    load_out  = (state_q == S_TICK_HOLD) && (!m_valid_q || m_axis_tready);

    ram_re    = (state_q == S_NOTE_RD) || (state_q == S_TICK_RUN);
    ram_raddr = (state_q == S_NOTE_RD) ? note_idx_q : cnt_q;
    if (state_q == S_NOTE_WR) begin
      ram_we    = 1'b1;
      ram_waddr = note_idx_q;
      ram_wdata = {phase_eff, vel_q};
    end else begin
      ram_we    = voice_on;
      ram_waddr = s1_idx_q;
      ram_wdata = {phase_eff + step_tbl[s1_idx_q], rd_vel};
    end
  end

  psvb_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      gain_q     <= GAIN_RESET;
      active_q   <= '0;
      valid_q    <= '0;
      cnt_q      <= '0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      mac_ctl_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      mac_ctl_q  <= '{vld: s1_vld_q, first: s1_first_q, last: s1_last_q};
      if (voice_on) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            case (in_mode)
              MODE_NOTE_ON, MODE_NOTE_OFF: begin
                if (note_ok) begin
                  if (in_mode == MODE_NOTE_ON && in_vel != '0) begin
                    state_q <= S_NOTE_RD;
                  end else begin
                    active_q[in_idx] <= 1'b0;
                  end
                end
              end
              MODE_TICK: begin
                cnt_q   <= '0;
                state_q <= S_TICK_RUN;
              end
              MODE_CLEAR: begin
                active_q <= '0;
                valid_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_NOTE_RD: begin
          state_q <= S_NOTE_WR;
        end
        S_NOTE_WR: begin
          valid_q[note_idx_q]  <= 1'b1;
          active_q[note_idx_q] <= 1'b1;
          state_q              <= S_IDLE;
        end
        S_TICK_RUN: begin
          s1_vld_q   <= 1'b1;
          s1_first_q <= (cnt_q == '0);
          s1_last_q  <= (cnt_q == LAST_V);
          if (cnt_q == LAST_V) begin
            state_q <= S_TICK_WAIT;
          end else begin
            cnt_q <= cnt_q + VW'(1);
          end
        end
        S_TICK_WAIT: begin
          if (scale_done) begin
            state_q <= S_TICK_HOLD;
          end
        end
        S_TICK_HOLD: begin
          if (load_out) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      note_idx_q <= in_idx;
      vel_q      <= in_vel;
    end
    s1_idx_q    <= cnt_q;
    mac_phase_q <= phase_eff;
    mac_vel_q   <= voice_on ? rd_vel : '0;
    if (load_out) begin
      out_data_q <= {|active_q, scale_sample};
    end
  end

  psvb_mac #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .ACC_W           (ACC_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl_q),
    .phase_i   (mac_phase_q),
    .vel_i     (mac_vel_q),
    .gain_i    (gain_q),
    .acc_o     (mac_acc),
    .acc_vld_o (mac_acc_vld)
  );

  psvb_scale #(
    .ACC_W (ACC_W)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_acc_vld),
    .acc_i    (mac_acc),
    .sample_o (scale_sample),
    .done_o   (scale_done)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

  // walk reads one voice ahead of the write-back, so no forwarding is needed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("voice RAM read and write hit the same entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_acc_vld |-> state_q == S_TICK_WAIT)
    else $error("mix sum finished outside a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> state_q == S_TICK_WAIT)
    else $error("scaled sample arrived outside a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[SAMPLE_W] |-> m_axis_tdata[SAMPLE_W-1:0] == '0)
    else $error("nonzero sample with no active voice");

endmodule
`default_nettype wire
